>>> sv/tnst_pkg.sv
// ----------------------------------------------------------------------------
// tnst_pkg
// Shared widths, masks and codes for the tone and noise tick unit.
// ----------------------------------------------------------------------------
package tnst_pkg;

  // Fixed geometry of the tone bank
  localparam int TONE_SLOTS   = 4;
  localparam int SLOT_W       = 2;
  localparam int WORD_W       = 16;
  localparam int CNT_W        = 12;
  localparam int NOISE_W      = 32;
  localparam int TICK_W       = 32;

  // Field widths
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 8;
  localparam int RAND_W       = 8;

  // Stream payload widths (padded to whole bytes)
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 48;

  // Highest address that selects a tone word byte
  localparam logic [ADDR_W-1:0] ADDR_TONE_LAST = 4'd7;

  // Noise feedback taps, feedback enters at the top bit
  localparam int TAP_A        = 25;
  localparam int TAP_B        = 19;
  localparam int TAP_C        = 11;
  localparam int TAP_D        = 9;

  // Result item
  typedef struct packed {
    logic [TICK_W-1:0]     tick_count;
    logic [RAND_W-1:0]     random_byte;
    logic [TONE_SLOTS-1:0] tone_squares;
    logic [TONE_SLOTS-1:0] tone_pulses;
  } result_t;

endpackage

>>> sv/tone_noise_sound_tick_unit.sv
// ----------------------------------------------------------------------------
// tone_noise_sound_tick_unit
// Tone counters, square outputs and XNOR noise register, one chip tick per
// input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave-side transaction is one chip tick carrying the latched bus
//   address and data byte. Addresses 0..7 load the low (even) or high (odd)
//   byte of a tone word; other addresses only advance time.
//   Each tick produces exactly one master-side transaction holding the tone
//   pulses, the square outputs, the low noise byte and the tick count.
//   A result lands in the result register, or in the skid entry if that
//   is full. Throughput: one tick per cycle while s_tready is high, set by
//   the single pass of state update logic between the input handshake and
//   the result register. The result register is backed by one skid entry,
//   so a new tick is still taken while a result waits; s_tready drops only
//   when both are occupied and rises again once the receiver takes a result.
//   Reset clears all tone words, counters, squares, the noise register and
//   the tick count, and empties the output buffer.
// ----------------------------------------------------------------------------
module tone_noise_sound_tick_unit #(
  parameter int NUM_TONES = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  // tdata: reg_addr[3:0], reg_data[11:4], zero [15:12]
  input  logic [tnst_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // tdata: tone_pulses[3:0], tone_squares[7:4], random_byte[15:8],
  //        tick_count[47:16]
  output logic [tnst_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready
);
  import tnst_pkg::*;

  // Architectural state
  logic [WORD_W-1:0]     tone_words    [TONE_SLOTS];
  logic [CNT_W-1:0]      tone_counters [TONE_SLOTS];
  logic [TONE_SLOTS-1:0] square_bits;
  logic [NOISE_W-1:0]    noise_shift;
  logic [TICK_W-1:0]     ticks;

  // Next values
  logic [WORD_W-1:0]     tone_words_next    [TONE_SLOTS];
  logic [CNT_W-1:0]      tone_counters_next [TONE_SLOTS];
  logic [TONE_SLOTS-1:0] square_bits_next;
  logic [TONE_SLOTS-1:0] pulses;
  logic [NOISE_W-1:0]    noise_shift_next;
  logic [TICK_W-1:0]     ticks_next;

  // Output buffer
  result_t result_next;
  result_t out_reg;
  result_t skid_reg;
  logic    out_valid;
  logic    skid_valid;

  // Input unpack
  logic [ADDR_W-1:0] reg_addr;
  logic [DATA_W-1:0] reg_data;
  logic [SLOT_W-1:0] wr_slot;
  logic              push;
  logic              pop;

  assign reg_addr = s_tdata[ADDR_W-1:0];
  assign reg_data = s_tdata[ADDR_W +: DATA_W];
  assign wr_slot  = reg_addr[SLOT_W:1];

  assign s_tready = !skid_valid;
  assign push     = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  // Bus write, noise step and tone counters for one tick
  always_comb begin
    logic [CNT_W-1:0] c;
    ticks_next       = ticks + TICK_W'(1);
    noise_shift_next = {~(noise_shift[TAP_A] ^ noise_shift[TAP_B] ^
                          noise_shift[TAP_C] ^ noise_shift[TAP_D]),
                        noise_shift[NOISE_W-1:1]};
    square_bits_next = square_bits;
    pulses           = '0;
    c                = '0;
    for (int i = 0; i < TONE_SLOTS; i++) begin
      tone_words_next[i]    = tone_words[i];
      tone_counters_next[i] = tone_counters[i];
      if (i < NUM_TONES) begin
        if (reg_addr <= ADDR_TONE_LAST && wr_slot == SLOT_W'(i)) begin
          if (!reg_addr[0]) begin
            tone_words_next[i][DATA_W-1:0] = reg_data;
          end else begin
            tone_words_next[i][WORD_W-1:DATA_W] = reg_data;
          end
        end
        c = tone_counters[i] + CNT_W'(1);
        if (c > tone_words_next[i][CNT_W-1:0]) begin
          c                   = '0;
          pulses[i]           = 1'b1;
          square_bits_next[i] = ~square_bits[i];
        end
        tone_counters_next[i] = c;
      end
    end
    result_next.tone_pulses  = pulses;
    result_next.tone_squares = square_bits_next;
    result_next.random_byte  = noise_shift_next[RAND_W-1:0];
    result_next.tick_count   = ticks_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TONE_SLOTS; i++) begin
        tone_words[i]    <= '0;
        tone_counters[i] <= '0;
      end
      square_bits <= '0;
      noise_shift <= '0;
      ticks       <= '0;
    end else if (push) begin
      for (int i = 0; i < TONE_SLOTS; i++) begin
        tone_words[i]    <= tone_words_next[i];
        tone_counters[i] <= tone_counters_next[i];
      end
      square_bits <= square_bits_next;
      noise_shift <= noise_shift_next;
      ticks       <= ticks_next;
    end
  end

  // Result register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_reg   <= result_next;
        out_valid <= 1'b1;
      end else begin
        skid_reg   <= result_next;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_reg;

endmodule

>>> sv/tnst_checker.sv
// ----------------------------------------------------------------------------
// tnst_checker
// Port-level checks on the result stream of the tone and noise tick unit.
// ----------------------------------------------------------------------------
module tnst_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [tnst_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                             m_tvalid,
  input logic                             m_tready
);
  import tnst_pkg::*;

  result_t               res;
  logic                  out_acc;
  logic                  seen;
  logic [TICK_W-1:0]     last_tick;
  logic [TONE_SLOTS-1:0] last_sq;

  assign res     = m_tdata;
  assign out_acc = m_tvalid && m_tready;

  // Remember the previous delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= 1'b0;
      last_tick <= '0;
      last_sq   <= '0;
    end else if (out_acc) begin
      seen      <= 1'b1;
      last_tick <= res.tick_count;
      last_sq   <= res.tone_squares;
    end
  end

  // Output buffer is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  // Every accepted tick leaves a result on offer
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("no result offered after an accepted tick");

  // Delivered results count ticks without gaps or repeats
  a_tick_chain: assert property (@(posedge clk) disable iff (rst)
    (out_acc && seen) |-> (res.tick_count == last_tick + TICK_W'(1)))
    else $error("tick count not consecutive across results");

  // Square outputs change exactly where a pulse is reported
  a_square_toggle: assert property (@(posedge clk) disable iff (rst)
    (out_acc && seen) |-> (res.tone_squares == (last_sq ^ res.tone_pulses)))
    else $error("square outputs disagree with pulses");

  // A stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result withdrawn while stalled");

endmodule

bind tone_noise_sound_tick_unit tnst_checker u_tnst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
